FILE: design/mfrm_pkg.sv
`timescale 1ns / 1ps

package mfrm_pkg;

  // command width after the 4 bit gain: 15 * 32768 fits in 20 signed bits
  localparam int unsigned GainedWidth = 20;

  // pi/2 in Q30, used to build the sine table
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_YAW_OFFSET          = 3'd0,
    REG_SPEED_GAIN          = 3'd1,
    REG_ROTATION_ARM        = 3'd2,
    REG_INVERSE_WHEEL_SCALE = 3'd3
  } cfg_reg_e;

  // one velocity command
  typedef struct packed {
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_w;
    logic        [12:0] yaw_count;
  } cmd_t;

  // one set of wheel targets
  typedef struct packed {
    logic signed [15:0] wheel0_speed;
    logic signed [15:0] wheel1_speed;
    logic signed [15:0] wheel2_speed;
    logic signed [15:0] wheel3_speed;
  } wheel_t;

  // one register write
  typedef struct packed {
    cfg_reg_e    index;
    logic [15:0] value;
  } cfg_t;

  // per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // quarter-wave sine entry: Q30 Taylor series, rounded to tfb bits, clamped to 1.0
  function automatic logic [16:0] sine_entry(input int unsigned idx, input int unsigned stb,
                                             input int unsigned tfb);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    logic signed [63:0] one;
    x    = (64'(idx) * HalfPiQ30 + (64'd1 << (stb - 1))) >> stb;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = $signed(x);
    one  = 64'sd1 <<< tfb;
    for (int k = 1; k <= 8; k++) begin
      prod = (term * x2) >> 30;
      case (k)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        5:       term = prod / 64'd110;
        6:       term = prod / 64'd156;
        7:       term = prod / 64'd210;
        default: term = prod / 64'd272;
      endcase
      if (k[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (sum + (64'sd1 <<< (29 - tfb))) >>> (30 - tfb);
    if (v > one) begin
      v = one;
    end
    return v[16:0];
  endfunction

endpackage

FILE: design/mfrm_stream_if.sv
`timescale 1ns / 1ps

// valid/ready channel with a typed payload
interface mfrm_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mecanum_frame_rotate_mix_core.sv
`timescale 1ns / 1ps

// channel  | modport | payload            | transfer when
// ---------+---------+--------------------+----------------------------
// cmd_i    | sink    | vx, vy, w, yaw     | cmd_i.valid && cmd_i.ready
// wheel_o  | source  | four wheel speeds  | wheel_o.valid && wheel_o.ready
// cfg_i    | sink    | index, value       | cfg_i.valid (ready is held high)
//
// five register stages; one command per cycle unless a stalled output fills the pipeline;
// a result is shown on wheel_o once its command has passed through every stage register
// stages: gain and sine rom read, rotation products, mix sums, scale partial
// products, round and saturate into the output register
// each stage has its own valid bit and loads when it is empty or its successor moves,
// so bubbles close up and a stalled output holds without dropping or repeating items
// reset clears valid bits and loads the register defaults; no clearing pass
module mecanum_frame_rotate_mix_core #(
  parameter int unsigned SINE_TABLE_BITS    = 11,
  parameter int unsigned TRIG_FRACTION_BITS = 15
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mfrm_stream_if.sink   cmd_i,
  mfrm_stream_if.source wheel_o,
  mfrm_stream_if.sink   cfg_i
);

  localparam int unsigned MixWidth = TRIG_FRACTION_BITS + 29;

  // configuration registers
  logic [12:0] yaw_offset_q;
  logic [3:0]  speed_gain_q;
  logic [15:0] rotation_arm_q;
  logic [15:0] inverse_wheel_scale_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_offset_q          <= 13'd290;
      speed_gain_q          <= 4'd3;
      rotation_arm_q        <= 16'd362;
      inverse_wheel_scale_q <= 16'd256;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        mfrm_pkg::REG_YAW_OFFSET:          yaw_offset_q          <= cfg_i.data.value[12:0];
        mfrm_pkg::REG_SPEED_GAIN:          speed_gain_q          <= cfg_i.data.value[3:0];
        mfrm_pkg::REG_ROTATION_ARM:        rotation_arm_q        <= cfg_i.data.value;
        mfrm_pkg::REG_INVERSE_WHEEL_SCALE: inverse_wheel_scale_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // pipeline valid bits and per-stage ready chain
  logic [5:1]          vld_q;
  logic [5:1]          rdy;
  mfrm_pkg::stage_en_t en;

  always_comb begin
    rdy[5] = !vld_q[5] || wheel_o.ready;
    rdy[4] = !vld_q[4] || rdy[5];
    rdy[3] = !vld_q[3] || rdy[4];
    rdy[2] = !vld_q[2] || rdy[3];
    rdy[1] = !vld_q[1] || rdy[2];
    en.s1  = rdy[1];
    en.s2  = rdy[2];
    en.s3  = rdy[3];
    en.s4  = rdy[4];
    en.s5  = rdy[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) vld_q[1] <= cmd_i.valid;
      if (rdy[2]) vld_q[2] <= vld_q[1];
      if (rdy[3]) vld_q[3] <= vld_q[2];
      if (rdy[4]) vld_q[4] <= vld_q[3];
      if (rdy[5]) vld_q[5] <= vld_q[4];
    end
  end

  assign cmd_i.ready   = rdy[1];
  assign wheel_o.valid = vld_q[5];

  // datapath
  logic signed [MixWidth-1:0] mix [4];

  mfrm_rotate #(
    .SINE_TABLE_BITS   (SINE_TABLE_BITS),
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
    .MIX_WIDTH         (MixWidth)
  ) u_rotate (
    .clk_i         (clk_i),
    .en_i          (en),
    .cmd_i         (cmd_i.data),
    .yaw_offset_i  (yaw_offset_q),
    .speed_gain_i  (speed_gain_q),
    .rotation_arm_i(rotation_arm_q),
    .mix_o         (mix)
  );

  mfrm_wheel_scale #(
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS),
    .MIX_WIDTH         (MixWidth)
  ) u_wheel_scale (
    .clk_i                (clk_i),
    .en_i                 (en),
    .mix_i                (mix),
    .inverse_wheel_scale_i(inverse_wheel_scale_q),
    .wheel_o              (wheel_o.data)
  );

endmodule

FILE: design/mfrm_sine_rom.sv
`timescale 1ns / 1ps

// quarter-wave sine rom, two registered read ports (sine and cosine)
module mfrm_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS    = 11,
  parameter int unsigned TRIG_FRACTION_BITS = 15
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [SINE_TABLE_BITS:0]      addr_a_i,
  input  logic [SINE_TABLE_BITS:0]      addr_b_i,
  output logic [TRIG_FRACTION_BITS:0]   data_a_o,
  output logic [TRIG_FRACTION_BITS:0]   data_b_o
);

  localparam int unsigned TableLen  = (2 ** SINE_TABLE_BITS) + 1;
  localparam int unsigned DataWidth = TRIG_FRACTION_BITS + 1;

  logic [DataWidth-1:0] rom_mem [TableLen];

  // table contents fixed at elaboration
  for (genvar i = 0; i < TableLen; i++) begin : g_entry
    assign rom_mem[i] = DataWidth'(mfrm_pkg::sine_entry(i, SINE_TABLE_BITS,
                                                         TRIG_FRACTION_BITS));
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= rom_mem[addr_a_i];
      data_b_o <= rom_mem[addr_b_i];
    end
  end

endmodule

FILE: design/mfrm_rotate.sv
`timescale 1ns / 1ps

// stages 1 to 3: gain and trig lookup, rotation products, wheel mix sums
module mfrm_rotate #(
  parameter int unsigned SINE_TABLE_BITS    = 11,
  parameter int unsigned TRIG_FRACTION_BITS = 15,
  parameter int unsigned MIX_WIDTH          = TRIG_FRACTION_BITS + 29
) (
  input  logic                        clk_i,
  input  mfrm_pkg::stage_en_t         en_i,
  input  mfrm_pkg::cmd_t              cmd_i,
  input  logic [12:0]                 yaw_offset_i,
  input  logic [3:0]                  speed_gain_i,
  input  logic [15:0]                 rotation_arm_i,
  output logic signed [MIX_WIDTH-1:0] mix_o [4]
);

  localparam int unsigned Gw       = mfrm_pkg::GainedWidth;
  localparam int unsigned PhWidth  = SINE_TABLE_BITS + 2;
  localparam int unsigned AddrW    = SINE_TABLE_BITS + 1;
  localparam int unsigned TrigW    = TRIG_FRACTION_BITS + 2;
  localparam int unsigned ProdW    = Gw + TrigW;
  localparam int unsigned ArmProdW = Gw + 17;
  localparam int unsigned Quarter  = 2 ** SINE_TABLE_BITS;

  // stage 1: gain
  logic signed [Gw-1:0] gvx_d, gvy_d, gw_d;
  logic signed [Gw-1:0] gvx_q, gvy_q, gw_q;
  logic signed [4:0]    gain_s;

  assign gain_s = $signed({1'b0, speed_gain_i});
  assign gvx_d  = cmd_i.cmd_vx * gain_s;
  assign gvy_d  = cmd_i.cmd_vy * gain_s;
  assign gw_d   = cmd_i.cmd_w * gain_s;

  // stage 1: phase and table addresses
  logic [12:0]                  p13;
  logic [PhWidth-1:0]           ph;
  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [AddrW-1:0]             idx_fwd, idx_rev, sin_addr, cos_addr;
  logic [TRIG_FRACTION_BITS:0]  sin_mag, cos_mag;
  logic                         sin_neg_q, cos_neg_q;

  assign p13 = cmd_i.yaw_count - yaw_offset_i;

  if (SINE_TABLE_BITS <= 11) begin : g_phase_drop
    assign ph = p13[12 -: PhWidth];
  end else begin : g_phase_widen
    assign ph = {p13, {(SINE_TABLE_BITS - 11){1'b0}}};
  end

  assign quad     = ph[PhWidth-1 -: 2];
  assign idx      = ph[SINE_TABLE_BITS-1:0];
  assign idx_fwd  = {1'b0, idx};
  assign idx_rev  = AddrW'(Quarter) - idx_fwd;
  // cosine sits one quadrant ahead of sine
  assign sin_addr = quad[0] ? idx_rev : idx_fwd;
  assign cos_addr = quad[0] ? idx_fwd : idx_rev;

  mfrm_sine_rom #(
    .SINE_TABLE_BITS   (SINE_TABLE_BITS),
    .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .en_i    (en_i.s1),
    .addr_a_i(sin_addr),
    .addr_b_i(cos_addr),
    .data_a_o(sin_mag),
    .data_b_o(cos_mag)
  );

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      gvx_q     <= gvx_d;
      gvy_q     <= gvy_d;
      gw_q      <= gw_d;
      sin_neg_q <= quad[1];
      cos_neg_q <= quad[1] ^ quad[0];
    end
  end

  // stage 2: signed trig values and rotation products
  logic signed [TrigW-1:0]    sin_mag_s, cos_mag_s, sn, cs;
  logic signed [ProdW-1:0]    p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [ArmProdW-1:0] p_w_q;
  logic signed [16:0]         arm_s;

  assign sin_mag_s = $signed({1'b0, sin_mag});
  assign cos_mag_s = $signed({1'b0, cos_mag});
  assign sn        = sin_neg_q ? -sin_mag_s : sin_mag_s;
  assign cs        = cos_neg_q ? -cos_mag_s : cos_mag_s;
  assign arm_s     = $signed({1'b0, rotation_arm_i});

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p_xc_q <= gvx_q * cs;
      p_ys_q <= gvy_q * sn;
      p_xs_q <= gvx_q * sn;
      p_yc_q <= gvy_q * cs;
      p_w_q  <= gw_q * arm_s;
    end
  end

  // stage 3: chassis frame components and wheel mix
  logic signed [MIX_WIDTH-1:0] x, y, wt;

  assign x  = MIX_WIDTH'(p_ys_q) - MIX_WIDTH'(p_xc_q);
  assign y  = MIX_WIDTH'(p_xs_q) + MIX_WIDTH'(p_yc_q);
  assign wt = MIX_WIDTH'(p_w_q) <<< (TRIG_FRACTION_BITS - 8);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      mix_o[0] <= x - y + wt;
      mix_o[1] <= wt - x - y;
      mix_o[2] <= y - x + wt;
      mix_o[3] <= x + y + wt;
    end
  end

endmodule

FILE: design/mfrm_wheel_scale.sv
`timescale 1ns / 1ps

// stages 4 and 5: multiply by the inverse scale in two partial products, round, saturate
module mfrm_wheel_scale #(
  parameter int unsigned TRIG_FRACTION_BITS = 15,
  parameter int unsigned MIX_WIDTH          = TRIG_FRACTION_BITS + 29
) (
  input  logic                        clk_i,
  input  mfrm_pkg::stage_en_t         en_i,
  input  logic signed [MIX_WIDTH-1:0] mix_i [4],
  input  logic [15:0]                 inverse_wheel_scale_i,
  output mfrm_pkg::wheel_t            wheel_o
);

  localparam int unsigned LoW  = (MIX_WIDTH + 1) / 2;
  localparam int unsigned HiW  = MIX_WIDTH - LoW;
  localparam int unsigned ResW = MIX_WIDTH + 17;
  localparam int unsigned RndShift = TRIG_FRACTION_BITS + 8;

  logic signed [16:0]        inv_s;
  logic [LoW+15:0]           pl_q [4];
  logic signed [HiW+16:0]    ph_q [4];
  logic signed [ResW-1:0]    prod [4];
  logic signed [ResW-1:0]    rnd [4];
  logic signed [15:0]        sat [4];

  assign inv_s = $signed({1'b0, inverse_wheel_scale_i});

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [LoW-1:0]         lo;
    logic signed [HiW-1:0]  hi;

    assign lo = mix_i[j][LoW-1:0];
    assign hi = mix_i[j][MIX_WIDTH-1:LoW];

    // stage 4: partial products
    always_ff @(posedge clk_i) begin
      if (en_i.s4) begin
        pl_q[j] <= lo * inverse_wheel_scale_i;
        ph_q[j] <= hi * inv_s;
      end
    end

    // stage 5: combine, round half up, saturate
    assign prod[j] = (ResW'(ph_q[j]) <<< LoW) + ResW'($signed({1'b0, pl_q[j]}));
    assign rnd[j]  = (prod[j] + (ResW'(1) <<< (RndShift - 1))) >>> RndShift;

    always_comb begin
      if (rnd[j] > ResW'(32767)) begin
        sat[j] = 16'sh7fff;
      end else if (rnd[j] < -ResW'(32768)) begin
        sat[j] = -16'sh8000;
      end else begin
        sat[j] = rnd[j][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      wheel_o.wheel0_speed <= sat[0];
      wheel_o.wheel1_speed <= sat[1];
      wheel_o.wheel2_speed <= sat[2];
      wheel_o.wheel3_speed <= sat[3];
    end
  end

endmodule

FILE: design/mfrm_checker.sv
`timescale 1ns / 1ps

// port-level checks on the core
module mfrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_data_i
);

  localparam logic [2:0] PipeDepth = 3'd5;

  // items in flight
  logic [2:0] cnt_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt_q <= cnt_q + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PipeDepth)
    else $error("more items in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 3'd0)
    else $error("result shown with no item in flight");

endmodule

bind mecanum_frame_rotate_mix_core mfrm_checker u_mfrm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (cmd_i.valid),
  .in_ready_i (cmd_i.ready),
  .out_valid_i(wheel_o.valid),
  .out_ready_i(wheel_o.ready),
  .out_data_i (wheel_o.data)
);
